### design/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// Byte-stream frame deframer package
// Shared types and constants: header layout, register indexes and the
// result item that leaves the block.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    // Header window geometry.
    localparam int unsigned HEADER_BYTES = 16;

    // Sync marker at the front of the header and guard word at its end.
    localparam logic [7:0] SYNC_A5  = 8'hA5;
    localparam logic [7:0] SYNC_5A  = 8'h5A;
    localparam logic [7:0] TAIL_B0  = 8'h78;
    localparam logic [7:0] TAIL_B1  = 8'h56;
    localparam logic [7:0] TAIL_B2  = 8'h34;
    localparam logic [7:0] TAIL_B3  = 8'h12;

    // Byte offsets of the little-endian header fields.
    localparam int unsigned OFS_CHECKSUM = 4;
    localparam int unsigned OFS_COMMAND  = 6;
    localparam int unsigned OFS_LENGTH   = 8;
    localparam int unsigned OFS_VERSION  = 10;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERIFY_CHECKSUM = 1'b0,
        CFG_MAX_PAYLOAD_LEN = 1'b1
    } t_cfg_idx;

    // Frame status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // Reset values of the registers.
    localparam logic        VERIFY_RESET  = 1'b1;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    // Sliding header window, byte 0 is the oldest.
    typedef logic [HEADER_BYTES-1:0][7:0] t_window;

    // One result item.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        status;
        logic [15:0] command;
        logic [15:0] payload_length;
        logic [15:0] version;
        logic [15:0] header_checksum;
    } t_result;

endpackage

### design/bsfd_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface bsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### design/bsfd_out_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries one payload byte or frame end per item.
// ----------------------------------------------------------------------------
interface bsfd_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic        status;
    logic [15:0] command;
    logic [15:0] payload_length;
    logic [15:0] version;
    logic [15:0] header_checksum;

    modport source (
        output valid, output payload_valid, output payload_byte,
        output frame_done, output status, output command,
        output payload_length, output version, output header_checksum,
        input  ready
    );
    modport sink (
        input  valid, input payload_valid, input payload_byte,
        input  frame_done, input status, input command,
        input  payload_length, input version, input header_checksum,
        output ready
    );
endinterface

### design/byte_stream_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Byte-stream frame deframer
// Searches a byte stream for a 16-byte header, then passes the payload
// through, sums it and reports the header fields and status at frame end.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on i_byte, one per item. While searching, a byte produces no
// result unless it completes a valid header of zero payload length. Each
// payload byte produces one result item on o_result with payload_valid set;
// the last one also carries frame_done, the status and the header fields.
// Configuration (verify_checksum, max_payload_len) is written through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle. The block does
// not enforce this itself. Each accepted byte's result is registered in the
// output register. Throughput is one byte per cycle while the receiver takes
// every result: the header compare, field extraction and the 16-bit sum all
// sit between the state registers and the single output register.
// When the receiver stalls, the output register holds its item and i_byte
// is not ready until that item is taken: i_byte is ready whenever the
// output register is empty or is being drained in the same cycle.
// Reset clears the window, the frame state and the output register's valid flag, and
// restores the register defaults (checking on, length limit 1024).
// ----------------------------------------------------------------------------
module byte_stream_frame_deframer_core
    import bsfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsfd_in_if.sink               i_byte,
    bsfd_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic        r_verify;
    logic [15:0] r_max_len;

    // Frame state.
    t_window     r_window;
    t_window     n_window;
    logic        r_in_payload;
    logic        n_in_payload;
    logic [15:0] r_remaining;
    logic [15:0] n_remaining;
    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [15:0] r_checksum;
    logic [15:0] n_checksum;
    logic [15:0] r_command;
    logic [15:0] n_command;
    logic [15:0] r_length;
    logic [15:0] n_length;
    logic [15:0] r_version;
    logic [15:0] n_version;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        n_produce;

    logic        accept;
    logic        hdr_ok;
    t_window     shifted;

    // Input is taken whenever the output register is free or draining.
    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    // Window after the new byte is shifted in.
    always_comb begin
        for (int i = 0; i < HEADER_BYTES - 1; i++) begin
            shifted[i] = r_window[i+1];
        end
        shifted[HEADER_BYTES-1] = i_byte.byte_in;
    end

    // Parallel header compare on the shifted window.
    assign hdr_ok = (shifted[0] == SYNC_A5) && (shifted[1] == SYNC_A5) &&
                    (shifted[2] == SYNC_5A) && (shifted[3] == SYNC_5A) &&
                    (shifted[12] == TAIL_B0) && (shifted[13] == TAIL_B1) &&
                    (shifted[14] == TAIL_B2) && (shifted[15] == TAIL_B3) &&
                    ({shifted[OFS_LENGTH+1], shifted[OFS_LENGTH]} <= r_max_len);

    // Next frame state and result for the byte on the input.
    always_comb begin
        n_window     = r_window;
        n_in_payload = r_in_payload;
        n_remaining  = r_remaining;
        n_sum        = r_sum;
        n_checksum   = r_checksum;
        n_command    = r_command;
        n_length     = r_length;
        n_version    = r_version;
        n_out        = '0;
        n_produce    = 1'b0;

        if (r_in_payload) begin
            // Pass the payload byte through and close the frame on the last one.
            n_sum               = r_sum + {8'd0, i_byte.byte_in};
            n_remaining         = r_remaining - 16'd1;
            n_produce           = 1'b1;
            n_out.payload_valid = 1'b1;
            n_out.payload_byte  = i_byte.byte_in;
            if (r_remaining == 16'd1) begin
                n_in_payload          = 1'b0;
                n_out.frame_done      = 1'b1;
                n_out.status          = (r_verify && (n_sum != r_checksum))
                                        ? STATUS_MISMATCH : STATUS_OK;
                n_out.command         = r_command;
                n_out.payload_length  = r_length;
                n_out.version         = r_version;
                n_out.header_checksum = r_checksum;
            end
        end else begin
            n_window = shifted;
            if (hdr_ok) begin
                // Latch the header and clear the window so it cannot match again.
                n_checksum  = {shifted[OFS_CHECKSUM+1], shifted[OFS_CHECKSUM]};
                n_command   = {shifted[OFS_COMMAND+1], shifted[OFS_COMMAND]};
                n_length    = {shifted[OFS_LENGTH+1], shifted[OFS_LENGTH]};
                n_version   = {shifted[OFS_VERSION+1], shifted[OFS_VERSION]};
                n_sum       = 16'd0;
                n_remaining = n_length;
                n_window    = '0;
                if (n_length == 16'd0) begin
                    // Empty frame: report at once against a zero sum.
                    n_produce             = 1'b1;
                    n_out.frame_done      = 1'b1;
                    n_out.status          = (r_verify && (n_checksum != 16'd0))
                                            ? STATUS_MISMATCH : STATUS_OK;
                    n_out.command         = n_command;
                    n_out.payload_length  = n_length;
                    n_out.version         = n_version;
                    n_out.header_checksum = n_checksum;
                end else begin
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify  <= VERIFY_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VERIFY_CHECKSUM: r_verify  <= i_cfg_data[0];
                CFG_MAX_PAYLOAD_LEN: r_max_len <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Frame state registers, updated on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_in_payload <= 1'b0;
            r_remaining  <= 16'd0;
            r_sum        <= 16'd0;
        end else if (accept) begin
            r_window     <= n_window;
            r_in_payload <= n_in_payload;
            r_remaining  <= n_remaining;
            r_sum        <= n_sum;
        end
    end

    // Held header fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum <= 16'd0;
            r_command  <= 16'd0;
            r_length   <= 16'd0;
            r_version  <= 16'd0;
        end else if (accept) begin
            r_checksum <= n_checksum;
            r_command  <= n_command;
            r_length   <= n_length;
            r_version  <= n_version;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_produce;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_produce) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.payload_valid   = r_out.payload_valid;
    assign o_result.payload_byte    = r_out.payload_byte;
    assign o_result.frame_done      = r_out.frame_done;
    assign o_result.status          = r_out.status;
    assign o_result.command         = r_out.command;
    assign o_result.payload_length  = r_out.payload_length;
    assign o_result.version         = r_out.version;
    assign o_result.header_checksum = r_out.header_checksum;

`ifndef NO_ASSERTIONS
    // A frame in progress always has bytes left to take.
    a_remaining_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_remaining != 16'd0))
        else $error("payload state with zero bytes remaining");

    // Every result is either a payload byte or a frame end.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.payload_valid || r_out.frame_done))
        else $error("result item is neither payload nor frame end");

    // A payload byte always yields a payload result in the next cycle.
    a_payload_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_in_payload) |=> (r_out_valid && r_out.payload_valid))
        else $error("payload byte produced no result");

    // An accepted header leaves the window cleared.
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_in_payload && hdr_ok) |=> (r_window == '0))
        else $error("window not cleared after header");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Byte-stream frame deframer testbench
// Feeds the deframer a byte stream of framed and broken headers, payloads
// and noise, under several register settings, with random idling on both
// channels. A scoreboard models the deframer, queues the result item that
// each accepted byte should cause and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_IDLE       = 11;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 227;
    localparam int REPORT_LIMIT   = 10;

    // Deframer model plus the queue of result items still to arrive.
    class frame_scoreboard;
        t_result     due_results[$];
        t_window     hdr_window  = '0;
        logic        in_frame    = 1'b0;
        logic [15:0] bytes_left  = '0;
        logic [15:0] payload_sum = '0;
        logic [15:0] frame_cks   = '0;
        logic [15:0] frame_cmd   = '0;
        logic [15:0] frame_len   = '0;
        logic [15:0] frame_ver   = '0;
        logic        chk_enable  = VERIFY_RESET;
        logic [15:0] len_limit   = MAX_LEN_RESET;
        int          failures     = 0;
        int          results_seen = 0;
        int          frames_ok    = 0;
        int          frames_bad   = 0;
        int          payload_seen = 0;

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VERIFY_CHECKSUM: chk_enable = data[0];
                CFG_MAX_PAYLOAD_LEN: len_limit = data[15:0];
                default: ;
            endcase
        endfunction

        // The item that ends a frame carries the held header and the status.
        function t_result close_frame(t_result r);
            r.frame_done      = 1'b1;
            r.status          = (chk_enable && payload_sum != frame_cks) ?
                                STATUS_MISMATCH : STATUS_OK;
            r.command         = frame_cmd;
            r.payload_length  = frame_len;
            r.version         = frame_ver;
            r.header_checksum = frame_cks;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            t_result r;
            r = '0;
            if (in_frame) begin
                // Payload bytes bypass the window and pass straight through.
                payload_sum = payload_sum + {8'h00, b};
                bytes_left  = bytes_left - 16'd1;
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                if (bytes_left == 16'd0) begin
                    in_frame = 1'b0;
                    r = close_frame(r);
                end
                due_results.push_back(r);
            end else begin
                // Searching: slide the byte in and look for a complete header.
                hdr_window = {b, hdr_window[HEADER_BYTES-1:1]};
                if (hdr_window[0] == SYNC_A5 && hdr_window[1] == SYNC_A5 &&
                    hdr_window[2] == SYNC_5A && hdr_window[3] == SYNC_5A &&
                    hdr_window[12] == TAIL_B0 && hdr_window[13] == TAIL_B1 &&
                    hdr_window[14] == TAIL_B2 && hdr_window[15] == TAIL_B3 &&
                    {hdr_window[OFS_LENGTH+1], hdr_window[OFS_LENGTH]} <= len_limit) begin
                    frame_cks   = {hdr_window[OFS_CHECKSUM+1], hdr_window[OFS_CHECKSUM]};
                    frame_cmd   = {hdr_window[OFS_COMMAND+1], hdr_window[OFS_COMMAND]};
                    frame_len   = {hdr_window[OFS_LENGTH+1], hdr_window[OFS_LENGTH]};
                    frame_ver   = {hdr_window[OFS_VERSION+1], hdr_window[OFS_VERSION]};
                    payload_sum = '0;
                    bytes_left  = frame_len;
                    hdr_window  = '0;
                    if (frame_len == 16'd0) begin
                        due_results.push_back(close_frame(r));
                    end else begin
                        in_frame = 1'b1;
                    end
                end
            end
        endfunction

        function string describe(t_result r);
            return $sformatf({"pv=%0b byte=%02h done=%0b st=%0b ",
                              "cmd=%04h len=%04h ver=%04h cks=%04h"},
                             r.payload_valid, r.payload_byte, r.frame_done, r.status,
                             r.command, r.payload_length, r.version, r.header_checksum);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result item: %s", describe(got));
                end
                return;
            end
            want = due_results.pop_front();
            results_seen++;
            if (want.payload_valid) begin
                payload_seen++;
            end
            if (want.frame_done) begin
                if (want.status == STATUS_OK) begin
                    frames_ok++;
                end else begin
                    frames_bad++;
                end
            end
            if (got.payload_valid !== want.payload_valid ||
                got.payload_byte !== want.payload_byte ||
                got.frame_done !== want.frame_done ||
                got.status !== want.status ||
                got.command !== want.command ||
                got.payload_length !== want.payload_length ||
                got.version !== want.version ||
                got.header_checksum !== want.header_checksum) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result item %0d differs", results_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bsfd_in_if  byte_if ();
    bsfd_out_if res_if ();

    frame_scoreboard sb = new();

    int bytes_sent  = 0;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    byte_stream_frame_deframer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one byte after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= b;
        do @(posedge i_clk); while (byte_if.ready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // A full header; bad_pos, when not negative, corrupts one marker byte.
    task automatic send_header(input logic [15:0] cks, input logic [15:0] cmd,
                               input logic [15:0] len, input logic [15:0] ver,
                               input int bad_pos);
        logic [7:0] hdr [HEADER_BYTES];
        hdr[0]              = SYNC_A5;
        hdr[1]              = SYNC_A5;
        hdr[2]              = SYNC_5A;
        hdr[3]              = SYNC_5A;
        hdr[OFS_CHECKSUM]   = cks[7:0];
        hdr[OFS_CHECKSUM+1] = cks[15:8];
        hdr[OFS_COMMAND]    = cmd[7:0];
        hdr[OFS_COMMAND+1]  = cmd[15:8];
        hdr[OFS_LENGTH]     = len[7:0];
        hdr[OFS_LENGTH+1]   = len[15:8];
        hdr[OFS_VERSION]    = ver[7:0];
        hdr[OFS_VERSION+1]  = ver[15:8];
        hdr[12]             = TAIL_B0;
        hdr[13]             = TAIL_B1;
        hdr[14]             = TAIL_B2;
        hdr[15]             = TAIL_B3;
        if (bad_pos >= 0) begin
            hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(1, 255));
        end
        foreach (hdr[k]) begin
            send_byte(hdr[k]);
        end
    endtask

    // A frame within the current length limit, mostly short, checksum
    // right about half of the time.
    task automatic send_frame();
        int          len;
        int          pick;
        logic [7:0]  body[$];
        logic [7:0]  b;
        logic [15:0] sum;
        logic [15:0] cks;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            len = 0;
        end else if (pick < 85) begin
            len = $urandom_range(1, 12);
        end else if (pick < 97) begin
            len = $urandom_range(13, 40);
        end else begin
            len = $urandom_range(41, 150);
        end
        if (len > int'(sb.len_limit)) begin
            len = int'(sb.len_limit);
        end
        sum = '0;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = SYNC_A5;
                3: b = SYNC_5A;
                default: b = 8'($urandom);
            endcase
            body.push_back(b);
            sum = sum + {8'h00, b};
        end
        cks = $urandom_range(0, 1) ? sum : 16'($urandom);
        send_header(cks, 16'($urandom), 16'(len), 16'($urandom), -1);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    // Stray bytes, leaning towards marker values.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: send_byte(SYNC_A5);
                1: send_byte(SYNC_5A);
                2: send_byte(TAIL_B0);
                3: send_byte(TAIL_B3);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // Hold the sender until every expected item is out, then let it settle.
    task automatic wait_for_results();
        byte_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    // Result receiver: random stalls, then take and check one item.
    initial begin
        t_result got;
        int      stall;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.payload_valid   = res_if.payload_valid;
            got.payload_byte    = res_if.payload_byte;
            got.frame_done      = res_if.frame_done;
            got.status          = res_if.status;
            got.command         = res_if.command;
            got.payload_length  = res_if.payload_length;
            got.version         = res_if.version;
            got.header_checksum = res_if.header_checksum;
            sb.check_result(got);
        end
    end

    // Main sequence: reset, directed frames, then random phases.
    initial begin
        int          phase_end;
        int          pick;
        int          r;
        logic        chk;
        logic [15:0] lim;
        byte_if.valid   <= 1'b0;
        byte_if.byte_in <= 8'h00;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_VERIFY_CHECKSUM;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-length frame with a nonzero checksum, then a two-byte frame
        // carrying the bytes FF and 01 with a correct checksum.
        send_header(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, -1);
        send_header(16'h0100, 16'h0000, 16'h0002, 16'hFFFF, -1);
        send_byte(8'hFF);
        send_byte(8'h01);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: begin chk = 1'b0; lim = 16'h0000; end
                1: begin chk = 1'b1; lim = 16'hFFFF; end
                2: begin chk = 1'b1; lim = 16'h0001; end
                3: begin chk = 1'b0; lim = 16'd300; end
                4: begin chk = 1'b1; lim = 16'($urandom_range(2, 40)); end
                5: begin chk = 1'b1; lim = MAX_LEN_RESET; end
                6: begin chk = 1'($urandom_range(0, 1)); lim = 16'($urandom); end
                default: begin chk = 1'b0; lim = 16'hFFFF; end
            endcase
            write_register(CFG_VERIFY_CHECKSUM, {{(CFG_DATA_W-1){1'b0}}, chk});
            write_register(CFG_MAX_PAYLOAD_LEN, lim);

            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end) begin
                no_idle = ($urandom_range(0, 6) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame();
                end else if (pick < 80) begin
                    // Header over the length limit: ignored, search goes on.
                    if (sb.len_limit != 16'hFFFF) begin
                        send_header(16'($urandom), 16'($urandom),
                                    16'($urandom_range(int'(sb.len_limit) + 1, 65535)),
                                    16'($urandom), -1);
                    end else begin
                        send_noise();
                    end
                end else if (pick < 90) begin
                    // Header with one broken marker byte.
                    r = $urandom_range(0, 7);
                    send_header(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)),
                                16'($urandom), (r < 4) ? r : r + 8);
                end else begin
                    send_noise();
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_for_results();
                end
            end
            no_idle = 1'b0;
        end
        wait_for_results();

        $display("Sent %0d bytes under %0d register settings; %0d result items checked.",
                 bytes_sent, NUM_PHASES + 1, sb.results_seen);
        $display("Frames ended: %0d with status ok, %0d with checksum mismatch;",
                 sb.frames_ok, sb.frames_bad);
        $display("%0d payload bytes passed through.", sb.payload_seen);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", sb.failures);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
